### hdl/b64_pkg.sv
package b64_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CAP_W       = 16;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] BASE_UPPER  = 8'h41;
    localparam logic [7:0] BASE_LOWER  = 8'h61;
    localparam logic [7:0] BASE_DIGIT  = 8'h30;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
        logic       empty_message;
    } b64_in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
        logic       overflow_error;
    } b64_out_t;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        b64_out_t [MAX_RESULTS-1:0]      words;
    } b64_burst_t;

    // Maps a 6-bit code onto the alphabet A-Z a-z 0-9 ~ _.
    function automatic logic [7:0] b64_char(input logic [5:0] code);
        logic [7:0] c8;
        c8 = {2'b00, code};
        priority if (code < 6'd26) begin
            return BASE_UPPER + c8;
        end else if (code < 6'd52) begin
            return BASE_LOWER + c8 - 8'd26;
        end else if (code < 6'd62) begin
            return BASE_DIGIT + c8 - 8'd52;
        end else if (code == 6'd62) begin
            return CHAR_TILDE;
        end else begin
            return CHAR_UNDER;
        end
    endfunction

endpackage

### hdl/b64_core.sv
module b64_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  b64_pkg::b64_in_t       s_data,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    output logic                   burst_valid,
    input  logic                   burst_ready,
    output b64_pkg::b64_burst_t    burst
);
    import b64_pkg::*;

    logic             in_valid_reg;
    b64_in_t          in_data_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [3:0]       carry_reg,   carry_next;
    logic [1:0]       phase_reg,   phase_next;
    logic [CAP_W-1:0] written_reg, written_next;
    logic             drop_reg,    drop_next;

    logic             take;
    logic             ends;
    logic [7:0]       chars [MAX_RESULTS];
    logic             eots  [MAX_RESULTS];
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] allowed;
    logic [CNT_W-1:0] emit_n;
    logic             overflow;
    logic [3:0]       new_carry;
    logic [1:0]       new_phase;
    logic [CAP_W-1:0] room;

    assign ends = in_data_reg.is_last | in_data_reg.empty_message;

    // Build the list of characters this word needs before capacity is applied.
    always_comb begin
        logic [CNT_W-1:0] k;
        logic [7:0]       b;
        k = '0;
        b = in_data_reg.byte_value;
        new_carry = carry_reg;
        new_phase = phase_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            chars[i] = CHAR_NUL;
            eots[i]  = 1'b0;
        end
        if (!in_data_reg.empty_message) begin
            unique case (phase_reg)
                2'd1: begin
                    chars[k] = b64_char({carry_reg[1:0], b[7:4]});
                    k = k + 1'b1;
                    new_carry = b[3:0];
                    new_phase = 2'd2;
                end
                2'd2: begin
                    chars[k] = b64_char({carry_reg, b[7:6]});
                    k = k + 1'b1;
                    chars[k] = b64_char(b[5:0]);
                    k = k + 1'b1;
                    new_carry = 4'd0;
                    new_phase = 2'd0;
                end
                default: begin
                    chars[k] = b64_char(b[7:2]);
                    k = k + 1'b1;
                    new_carry = {2'b00, b[1:0]};
                    new_phase = 2'd1;
                end
            endcase
        end
        if (ends) begin
            if (new_phase == 2'd1) begin
                chars[k] = b64_char({new_carry[1:0], 4'b0000});
                k = k + 1'b1;
                chars[k] = PAD_CHAR;
                k = k + 1'b1;
                chars[k] = PAD_CHAR;
                k = k + 1'b1;
            end else if (new_phase == 2'd2) begin
                chars[k] = b64_char({new_carry, 2'b00});
                k = k + 1'b1;
                chars[k] = PAD_CHAR;
                k = k + 1'b1;
            end
            chars[k] = CHAR_NUL;
            eots[k]  = 1'b1;
            k = k + 1'b1;
        end
        need = k;
    end

    // Capacity left for this message, saturated at the burst size.
    assign room = capacity_reg - written_reg;
    always_comb begin
        if (written_reg >= capacity_reg) begin
            allowed = '0;
        end else if (room >= CAP_W'(MAX_RESULTS)) begin
            allowed = CNT_W'(MAX_RESULTS);
        end else begin
            allowed = room[CNT_W-1:0];
        end
    end

    assign overflow = !drop_reg && (need > allowed);
    assign emit_n   = drop_reg ? '0 : (overflow ? allowed + 1'b1 : need);

    always_comb begin
        burst.count = emit_n;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (overflow && (CNT_W'(i) == allowed)) begin
                burst.words[i] = '{char_code: CHAR_NUL, end_of_text: 1'b1,
                                   overflow_error: 1'b1};
            end else begin
                burst.words[i] = '{char_code: chars[i], end_of_text: eots[i],
                                   overflow_error: 1'b0};
            end
        end
    end

    assign burst_valid = in_valid_reg && (emit_n != '0);
    assign take        = in_valid_reg && (burst_ready || (emit_n == '0));
    assign s_ready     = !in_valid_reg || take;

    always_comb begin
        carry_next   = carry_reg;
        phase_next   = phase_reg;
        written_next = written_reg;
        drop_next    = drop_reg;
        if (take) begin
            priority if (drop_reg) begin
                if (ends) begin
                    drop_next    = 1'b0;
                    carry_next   = 4'd0;
                    phase_next   = 2'd0;
                    written_next = '0;
                end
            end else if (overflow || ends) begin
                drop_next    = overflow && !ends;
                carry_next   = 4'd0;
                phase_next   = 2'd0;
                written_next = '0;
            end else begin
                carry_next   = new_carry;
                phase_next   = new_phase;
                written_next = written_reg + CAP_W'(need);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            capacity_reg <= '1;
            carry_reg    <= 4'd0;
            phase_reg    <= 2'd0;
            written_reg  <= '0;
            drop_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            carry_reg   <= carry_next;
            phase_reg   <= phase_next;
            written_reg <= written_next;
            drop_reg    <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

endmodule

### hdl/b64_outbuf.sv
module b64_outbuf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   burst_valid,
    output logic                   burst_ready,
    input  b64_pkg::b64_burst_t    burst,
    output logic                   m_valid,
    input  logic                   m_ready,
    output b64_pkg::b64_out_t      m_data
);
    import b64_pkg::*;

    logic [CNT_W-1:0]           cnt_reg;
    b64_out_t [MAX_RESULTS-1:0] words_reg;

    assign m_valid     = (cnt_reg != '0);
    assign m_data      = words_reg[0];
    // A new burst may load while the final word of the current one leaves.
    assign burst_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (burst_valid && burst_ready) begin
            cnt_reg <= burst.count;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (burst_valid && burst_ready) begin
            words_reg <= burst.words;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                words_reg[i] <= words_reg[i+1];
            end
        end
    end

endmodule

### hdl/base64_stream_encoder.sv
// Streaming Base64 encoder with '~' and '_' as codes 62 and 63. Each input
// word carries one message byte; a byte yields one character at group phases
// 0 and 1 and two at phase 2 (4/3 characters per byte on average), and the
// last byte of a message yields up to five words with flush, '=' padding and
// the NUL terminator. The output side, one character per cycle while m_ready
// is high from a five-entry shift buffer, sets the throughput; a new byte is
// taken as the held byte loads into the buffer. Each byte passes the input
// register and the shift buffer before its first character appears. A write
// to cfg_wr_data sets the per-message capacity (terminator included, reset
// 65535); the first character that would exceed it is replaced by one error
// word marked end of text and the rest of the message is dropped.
module base64_stream_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64_pkg::b64_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64_pkg::b64_out_t   m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import b64_pkg::*;

    logic       burst_valid;
    logic       burst_ready;
    b64_burst_t burst;

    b64_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    b64_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### hdl/b64_checker.sv
module b64_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input b64_pkg::b64_out_t   m_data
);
    import b64_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow_error |->
            m_data.end_of_text && (m_data.char_code == CHAR_NUL))
        else $error("error word not a terminating NUL");

    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.overflow_error |->
            ((m_data.char_code == CHAR_NUL) == m_data.end_of_text))
        else $error("terminator and end of text disagree");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (.*);

### tb/sv/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

    import b64_pkg::*;

    typedef enum logic [1:0] {
        GROUP_START,
        GROUP_ONE,
        GROUP_TWO
    } group_pos_e;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789~_";
    localparam logic [15:0] CAP_MAX   = 16'hFFFF;
    localparam int          SETTLE    = 10;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    b64_in_t     s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    b64_out_t    m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Encoder state as this bench sees it.
    logic [15:0] allowed_chars = CAP_MAX;
    logic [15:0] chars_sent    = '0;
    logic [3:0]  pending_bits  = '0;
    group_pos_e  group_pos     = GROUP_START;
    bit          discarding    = 1'b0;

    b64_out_t    expected_chars[$];
    b64_out_t    want;
    int          mismatches    = 0;
    int          words_encoded = 0;
    bit          idle_on       = 1'b1;

    base64_stream_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] code_to_char(input logic [5:0] code);
        return ALPHABET[(63 - int'(code)) * 8 +: 8];
    endfunction

    // Queues one character, or the error word once the capacity is used up.
    function automatic bit emit_char(input logic [7:0] ch, input logic eot);
        b64_out_t w;
        if (chars_sent >= allowed_chars) begin
            w.char_code      = CHAR_NUL;
            w.end_of_text    = 1'b1;
            w.overflow_error = 1'b1;
            expected_chars.push_back(w);
            return 1'b0;
        end
        chars_sent       = chars_sent + 16'd1;
        w.char_code      = ch;
        w.end_of_text    = eot;
        w.overflow_error = 1'b0;
        expected_chars.push_back(w);
        return 1'b1;
    endfunction

    function automatic void clear_group();
        pending_bits = '0;
        group_pos    = GROUP_START;
        chars_sent   = '0;
    endfunction

    // Returns 1 when the word is swallowed by a message being discarded.
    function automatic bit encode_word(input b64_in_t w);
        bit ends;
        bit ok;
        logic [7:0] b;
        ends = w.is_last || w.empty_message;
        ok   = 1'b1;
        b    = w.byte_value;
        if (discarding) begin
            if (ends) begin
                discarding = 1'b0;
                clear_group();
            end
            return 1'b1;
        end
        if (!w.empty_message) begin
            case (group_pos)
                GROUP_ONE: begin
                    ok = emit_char(code_to_char({pending_bits[1:0], b[7:4]}), 1'b0);
                    pending_bits = b[3:0];
                    group_pos    = GROUP_TWO;
                end
                GROUP_TWO: begin
                    ok = emit_char(code_to_char({pending_bits, b[7:6]}), 1'b0);
                    if (ok) ok = emit_char(code_to_char(b[5:0]), 1'b0);
                    pending_bits = '0;
                    group_pos    = GROUP_START;
                end
                default: begin
                    ok = emit_char(code_to_char(b[7:2]), 1'b0);
                    pending_bits = {2'b00, b[1:0]};
                    group_pos    = GROUP_ONE;
                end
            endcase
        end
        if (ok && ends) begin
            if (group_pos == GROUP_ONE) begin
                ok = emit_char(code_to_char({pending_bits[1:0], 4'b0000}), 1'b0);
                if (ok) ok = emit_char(PAD_CHAR, 1'b0);
                if (ok) ok = emit_char(PAD_CHAR, 1'b0);
            end else if (group_pos == GROUP_TWO) begin
                ok = emit_char(code_to_char({pending_bits, 2'b00}), 1'b0);
                if (ok) ok = emit_char(PAD_CHAR, 1'b0);
            end
            if (ok) ok = emit_char(CHAR_NUL, 1'b1);
        end
        if (!ok) begin
            discarding = !ends;
            clear_group();
        end else if (ends) begin
            clear_group();
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends one word and predicts its characters once it is taken.
    task automatic send_word(input logic [7:0] b, input logic is_end, input logic empty);
        b64_in_t w;
        w.byte_value    = b;
        w.is_last       = is_end;
        w.empty_message = empty;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(encode_word(w));
        words_encoded++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        wait_drained();
        // Words dropped inside a discarded message leave no trace in the queue.
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        allowed_chars = cap;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_data);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (m_data.char_code !== want.char_code) begin
                    $display("%0t: char_code expected %h actual %h",
                             $time, want.char_code, m_data.char_code);
                    mismatches++;
                end
                if (m_data.end_of_text !== want.end_of_text) begin
                    $display("%0t: end_of_text expected %b actual %b",
                             $time, want.end_of_text, m_data.end_of_text);
                    mismatches++;
                end
                if (m_data.overflow_error !== want.overflow_error) begin
                    $display("%0t: overflow_error expected %b actual %b",
                             $time, want.overflow_error, m_data.overflow_error);
                    mismatches++;
                end
            end
        end
    end

    always begin
        @(posedge aclk);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    task automatic test_group_phases();
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        // 0xF8 starts with code 62, so the tilde shows up.
        send_word(8'hF8, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h3E, 1'b1, 1'b0);
        send_word(8'hFB, 1'b0, 1'b0);
        send_word(8'hEF, 1'b0, 1'b0);
        send_word(8'hBF, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
    endtask

    task automatic test_message_endings();
        // Both end flags at once: the byte is ignored and the group is flushed.
        send_word(8'h12, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h9C, 1'b0, 1'b0);
        send_word(8'h41, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_capacity_overflow();
        set_capacity(16'h0000);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'hAA, 1'b1, 1'b0);
        set_capacity(16'h0001);
        send_word(8'h7F, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        // Four characters fit, the terminator overflows at the message end.
        set_capacity(16'h0004);
        send_word(8'hC3, 1'b1, 1'b0);
    endtask

    task automatic send_random_message();
        int len;
        bit empty_end;
        if ($urandom_range(0, 9) == 0) begin
            // Broken framing: flags land anywhere, then the message is closed.
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_word(pick_byte(), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end
            send_word(pick_byte(), 1'b1, 1'b0);
        end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
            empty_end = (len > 0) && ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++) begin
                send_word(pick_byte(), (i == len - 1) && !empty_end, 1'b0);
            end
            if (len == 0 || empty_end) send_word(pick_byte(), $urandom_range(0, 1), 1'b1);
        end
    endtask

    task automatic run_traffic(input logic [15:0] cap, input int quota, input bit toggle_idle);
        int start_count;
        int guard;
        set_capacity(cap);
        start_count = words_encoded;
        guard = 0;
        while (words_encoded - start_count < quota && guard < 200) begin
            if (toggle_idle && $urandom_range(0, 7) == 0) idle_on = !idle_on;
            send_random_message();
            if ($urandom_range(0, 11) == 0) wait_drained();
            guard++;
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(CAP_MAX, 35, 1'b1);
        run_traffic(16'($urandom_range(6, 30)), 35, 1'b1);
        run_traffic(16'h0000, 35, 1'b1);
        run_traffic(16'h0001, 35, 1'b1);
        run_traffic(16'($urandom_range(2, 12)), 35, 1'b1);
        run_traffic(16'($urandom_range(13, 65535)), 35, 1'b1);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_traffic(CAP_MAX, 45, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_group_phases();
        test_message_endings();
        test_capacity_overflow();
        test_random_traffic();
        test_steady_stream();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
